// ----- rtl/brta_pkg.sv -----
// ----------------------------------------------------------------------------
// brta_pkg: shared types and codes for the request tag and buffer allocator
// Opcodes, result kinds, error codes, sizing and the front/back command record.
// ----------------------------------------------------------------------------
package brta_pkg;

    // sizing; the port widths are fixed to these values
    localparam int TAG_SLOTS          = 32;
    localparam int BUFFER_COUNT       = 64;
    localparam int MAX_SEGMENTS       = 11;
    localparam int SECTORS_PER_BUFFER = 8;

    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_BARRIER = 3'd2;
    localparam logic [2:0] OP_FLUSH   = 3'd3;
    localparam logic [2:0] OP_DONE    = 3'd4;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_SEGMENT = 2'd1;
    localparam logic [1:0] KIND_NOTICE  = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_NORES = 2'd2;
    localparam logic [1:0] ERR_UNSUP = 2'd3;

    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_BARRIER  = 2'd1;
    localparam logic [1:0] REG_FLUSH    = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        logic [2:0]  opcode;
        logic [47:0] start_sector;
        logic [6:0]  sector_count;
        logic [4:0]  done_tag;
        logic [1:0]  done_status;
        logic        reject;
        logic [1:0]  error_code;
    } t_cmd;

endpackage

// ----- rtl/block_request_tag_and_buffer_allocator.sv -----
// ----------------------------------------------------------------------------
// block_request_tag_and_buffer_allocator: command tag and buffer allocator
// Front end classifies requests into a two-entry queue; back end runs the lists.
// ----------------------------------------------------------------------------
// Flow: a header or rejection is registered when the back end pops the request
//   from the queue; a completion notice follows the walk of the segment list.
// A read/write alternates link fetch and segment out for each segment; a
//   completion reads and pushes each segment, then gives the notice.
// Reset: synchronous, active low; registers to 0, lists rechained. The buffer
//   link memory is then rechained entry by entry before requests run.
module block_request_tag_and_buffer_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [47:0] i_start_sector,
    input  logic [6:0]  i_sector_count,
    input  logic [4:0]  i_done_tag,
    input  logic signed [1:0] i_done_status,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_item_kind,
    output logic [1:0]  o_error_code,
    output logic [1:0]  o_request_op,
    output logic [4:0]  o_request_tag,
    output logic [47:0] o_sector_number,
    output logic [3:0]  o_segment_total,
    output logic [5:0]  o_buffer_index,
    output logic [2:0]  o_last_sector_in_page,
    output logic signed [1:0] o_status_out,
    output logic [6:0]  o_sectors_done,
    output logic        o_last_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import brta_pkg::*;

    logic [47:0] r_capacity;
    logic        r_barrier_en, r_flush_en;
    logic        w_q_valid, w_q_pop;
    t_cmd        w_q_cmd;
    logic [1:0]  w_reg;

    // 64-bit registers at 8*i
    assign pready = 1'b1;
    assign w_reg  = paddr[4:3];

    always_comb begin
        prdata = '0;
        unique case (w_reg)
            REG_CAPACITY: prdata = {16'd0, r_capacity};
            REG_BARRIER:  prdata = {63'd0, r_barrier_en};
            REG_FLUSH:    prdata = {63'd0, r_flush_en};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= '0;
            r_barrier_en <= 1'b0;
            r_flush_en   <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg)
                REG_CAPACITY: r_capacity   <= pwdata[47:0];
                REG_BARRIER:  r_barrier_en <= pwdata[0];
                REG_FLUSH:    r_flush_en   <= pwdata[0];
                default: ;
            endcase
        end
    end

    brta_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_start_sector,
        .i_sector_count, .i_done_tag, .i_done_status,
        .i_capacity(r_capacity), .i_barrier_en(r_barrier_en), .i_flush_en(r_flush_en),
        .o_q_valid(w_q_valid), .i_q_pop(w_q_pop), .o_q_cmd(w_q_cmd)
    );

    brta_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_q_valid), .o_q_pop(w_q_pop), .i_q_cmd(w_q_cmd),
        .o_valid, .i_stall, .o_item_kind, .o_error_code, .o_request_op,
        .o_request_tag, .o_sector_number, .o_segment_total, .o_buffer_index,
        .o_last_sector_in_page, .o_status_out, .o_sectors_done, .o_last_item
    );
endmodule

// ----- rtl/brta_front.sv -----
// ----------------------------------------------------------------------------
// brta_front: request intake and classification
// Checks length, range and feature bits, then queues the request.
// ----------------------------------------------------------------------------
module brta_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_opcode,
    input  logic [47:0]        i_start_sector,
    input  logic [6:0]         i_sector_count,
    input  logic [4:0]         i_done_tag,
    input  logic [1:0]         i_done_status,
    input  logic [47:0]        i_capacity,
    input  logic               i_barrier_en,
    input  logic               i_flush_en,
    output logic               o_q_valid,
    input  logic               i_q_pop,
    output brta_pkg::t_cmd     o_q_cmd
);
    import brta_pkg::*;

    localparam int MAX_SECT = MAX_SEGMENTS * SECTORS_PER_BUFFER;

    // two-entry queue
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic [48:0] w_end;

    assign o_stall   = r_cnt[1];
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];
    assign w_end     = {1'b0, i_start_sector} + {42'd0, i_sector_count};

    always_comb begin
        w_cmd              = '0;
        w_cmd.opcode       = i_opcode;
        w_cmd.start_sector = i_start_sector;
        w_cmd.sector_count = i_sector_count;
        w_cmd.done_tag     = i_done_tag;
        w_cmd.done_status  = i_done_status;
        w_cmd.reject       = 1'b0;
        w_cmd.error_code   = ERR_NONE;
        case (i_opcode)
            OP_READ, OP_WRITE: begin
                if (i_sector_count == 7'd0 || 32'(i_sector_count) > MAX_SECT
                    || (i_opcode == OP_READ && (i_start_sector >= i_capacity
                        || w_end > {1'b0, i_capacity}))) begin
                    w_cmd.reject     = 1'b1;
                    w_cmd.error_code = ERR_RANGE;
                end
            end
            OP_BARRIER: begin
                if (!i_barrier_en) begin
                    w_cmd.reject     = 1'b1;
                    w_cmd.error_code = ERR_UNSUP;
                end
            end
            OP_FLUSH: begin
                if (!i_flush_en) begin
                    w_cmd.reject     = 1'b1;
                    w_cmd.error_code = ERR_UNSUP;
                end
            end
            OP_DONE: ;
            default: begin
                w_cmd.reject     = 1'b1;
                w_cmd.error_code = ERR_RANGE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_cmd;
                r_wp      <= ~r_wp;
            end
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

// ----- rtl/brta_back.sv -----
// ----------------------------------------------------------------------------
// brta_back: free-list engine and result sequencer
// Pops and pushes tags and buffers, one list link at a time; a new request is taken only in idle.
// ----------------------------------------------------------------------------
module brta_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  brta_pkg::t_cmd i_q_cmd,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_item_kind,
    output logic [1:0]     o_error_code,
    output logic [1:0]     o_request_op,
    output logic [4:0]     o_request_tag,
    output logic [47:0]    o_sector_number,
    output logic [3:0]     o_segment_total,
    output logic [5:0]     o_buffer_index,
    output logic [2:0]     o_last_sector_in_page,
    output logic [1:0]     o_status_out,
    output logic [6:0]     o_sectors_done,
    output logic           o_last_item
);
    import brta_pkg::*;

    localparam int TW  = $clog2(TAG_SLOTS + 1);
    localparam int TI  = $clog2(TAG_SLOTS);
    localparam int BW  = $clog2(BUFFER_COUNT + 1);
    localparam int BI  = $clog2(BUFFER_COUNT);
    localparam int SW  = $clog2(MAX_SEGMENTS + 1);
    localparam int LW  = $clog2(TAG_SLOTS * MAX_SEGMENTS);
    localparam int SPB = SECTORS_PER_BUFFER;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_POP  = 3'd1;
    localparam logic [2:0] ST_PUSH = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_SEG  = 3'd5;

    logic [2:0]    r_st;
    logic [TW-1:0] r_tag_link [TAG_SLOTS];
    logic [TW-1:0] r_tag_head;
    logic [TAG_SLOTS-1:0] r_busy;
    logic [BW-1:0] r_buf_link [BUFFER_COUNT];
    logic [BW-1:0] r_buf_head;
    logic [BW-1:0] r_link_q;
    logic [BW-1:0] r_free;
    logic [BW:0]   r_init;
    logic [6:0]    r_tag_secs [TAG_SLOTS];
    logic [BW-1:0] r_list [TAG_SLOTS * MAX_SEGMENTS];
    logic [BW-1:0] r_list_q;

    t_cmd          r_cmd;
    logic [TI-1:0] r_tag;
    logic [SW-1:0] r_nseg, r_seg;
    logic [6:0]    r_rem, r_nsec;
    logic          r_out;
    // registered result fields
    logic [1:0] r_kind, r_err, r_op, r_stat;
    logic [4:0] r_otag;
    logic [47:0] r_sect;
    logic [3:0] r_tot;
    logic [5:0] r_bi;
    logic [2:0] r_ls;
    logic [6:0] r_sd;
    logic r_last;

    logic          w_ready, w_busy_t;
    logic [SW-1:0] w_nseg, w_dseg;
    logic [TI-1:0] w_dtag;
    logic [6:0]    w_seglen;
    logic [LW-1:0] w_addr;

    assign w_ready = !o_valid || !i_stall;
    assign o_q_pop = (r_st == ST_IDLE) && r_init[BW] && i_q_valid && w_ready;
    assign w_dtag  = TI'(i_q_cmd.done_tag);
    assign w_busy_t = (32'(i_q_cmd.done_tag) < TAG_SLOTS) && r_busy[w_dtag];
    assign w_nseg  = SW'((32'(i_q_cmd.sector_count) + SPB - 1) / SPB);
    assign w_dseg  = (32'((32'(r_tag_secs[w_dtag]) + SPB - 1) / SPB) > MAX_SEGMENTS)
                     ? SW'(MAX_SEGMENTS)
                     : SW'((32'(r_tag_secs[w_dtag]) + SPB - 1) / SPB);
    assign w_seglen = (32'(r_rem) > SPB) ? 7'(SPB) : r_rem;
    assign w_addr  = LW'(32'(r_tag) * MAX_SEGMENTS + 32'(r_seg));

    assign o_valid = r_out;
    assign o_item_kind = r_kind;
    assign o_error_code = r_err;
    assign o_request_op = r_op;
    assign o_request_tag = r_otag;
    assign o_sector_number = r_sect;
    assign o_segment_total = r_tot;
    assign o_buffer_index = r_bi;
    assign o_last_sector_in_page = r_ls;
    assign o_status_out = r_stat;
    assign o_sectors_done = r_sd;
    assign o_last_item = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_tag_head <= '0;
            r_busy     <= '0;
            r_buf_head <= '0;
            r_free     <= BW'(BUFFER_COUNT);
            r_init     <= '0;
            r_out      <= 1'b0;
            for (int i = 0; i < TAG_SLOTS; i++) r_tag_link[i] <= TW'(i + 1);
        end else begin
            if (o_valid && !i_stall) r_out <= 1'b0;
            // chaining pass over the buffer link memory
            if (!r_init[BW]) begin
                r_buf_link[r_init[BI-1:0]] <= r_init[BW-1:0] + 1'b1;
                if (32'(r_init) == BUFFER_COUNT - 1) r_init <= {1'b1, {BW{1'b0}}};
                else r_init <= r_init + 1'b1;
            end
            unique case (r_st)
                ST_IDLE: if (o_q_pop) begin
                    r_cmd <= i_q_cmd;
                    r_out <= 1'b1;
                    r_err <= ERR_NONE; r_op <= '0; r_otag <= '0; r_sect <= '0;
                    r_tot <= '0; r_bi <= '0; r_ls <= '0; r_stat <= '0; r_sd <= '0;
                    r_last <= 1'b1;
                    if (i_q_cmd.reject) begin
                        r_kind <= KIND_REJECT; r_err <= i_q_cmd.error_code;
                        r_op <= (i_q_cmd.opcode > OP_FLUSH) ? 2'd0 : i_q_cmd.opcode[1:0];
                    end else if (i_q_cmd.opcode == OP_DONE) begin
                        if (!w_busy_t) begin
                            r_kind <= KIND_REJECT; r_err <= ERR_RANGE;
                            r_otag <= i_q_cmd.done_tag;
                        end else begin
                            r_out  <= 1'b0;
                            r_tag  <= w_dtag;
                            r_nseg <= w_dseg;
                            r_nsec <= r_tag_secs[w_dtag];
                            r_seg  <= '0;
                            r_st   <= (w_dseg == '0) ? ST_OUT : ST_RD;
                        end
                    end else if (32'(r_tag_head) >= TAG_SLOTS ||
                            (i_q_cmd.opcode[1] == 1'b0 && BW'(w_nseg) > r_free)) begin
                        r_kind <= KIND_REJECT; r_err <= ERR_NORES;
                        r_op <= i_q_cmd.opcode[1:0];
                    end else begin
                        r_tag_head <= r_tag_link[TI'(r_tag_head)];
                        r_busy[TI'(r_tag_head)] <= 1'b1;
                        r_tag <= TI'(r_tag_head);
                        r_kind <= KIND_HEADER; r_op <= i_q_cmd.opcode[1:0];
                        r_otag <= 5'(r_tag_head);
                        if (i_q_cmd.opcode[1] == 1'b0) begin
                            r_tag_secs[TI'(r_tag_head)] <= i_q_cmd.sector_count;
                            r_sect <= i_q_cmd.start_sector;
                            r_tot <= 4'(w_nseg);
                            r_last <= 1'b0;
                            r_nseg <= w_nseg; r_seg <= '0;
                            r_rem <= i_q_cmd.sector_count;
                            r_st <= ST_POP;
                        end else begin
                            r_tag_secs[TI'(r_tag_head)] <= 7'd0;
                        end
                    end
                end
                // fetch the link behind the head buffer
                ST_POP: begin
                    r_link_q <= r_buf_link[BI'(r_buf_head)];
                    r_st     <= ST_SEG;
                end
                ST_SEG: if (w_ready) begin
                    r_out <= 1'b1;
                    r_kind <= KIND_SEGMENT; r_sect <= '0; r_tot <= '0;
                    r_bi <= 6'(r_buf_head);
                    r_ls <= 3'(w_seglen - 7'd1);
                    r_last <= (r_seg + 1'b1 == r_nseg);
                    if (32'(r_buf_head) < BUFFER_COUNT)
                        r_buf_head <= r_link_q;
                    r_free <= r_free - 1'b1;
                    r_list[w_addr] <= r_buf_head;
                    r_rem <= r_rem - w_seglen;
                    r_seg <= r_seg + 1'b1;
                    r_st <= (r_seg + 1'b1 == r_nseg) ? ST_IDLE : ST_POP;
                end
                ST_RD: begin
                    r_list_q <= r_list[w_addr];
                    r_seg <= r_seg + 1'b1;
                    r_st  <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (32'(r_list_q) < BUFFER_COUNT && 32'(r_free) < BUFFER_COUNT) begin
                        r_buf_link[BI'(r_list_q)] <= r_buf_head;
                        r_buf_head <= r_list_q;
                        r_free <= r_free + 1'b1;
                    end
                    r_st <= (r_seg == r_nseg) ? ST_OUT : ST_RD;
                end
                ST_OUT: if (w_ready) begin
                    r_tag_link[r_tag] <= TW'(r_tag_head);
                    r_tag_head <= TW'(r_tag);
                    r_busy[r_tag] <= 1'b0;
                    r_out <= 1'b1;
                    r_kind <= KIND_NOTICE; r_err <= ERR_NONE; r_op <= '0;
                    r_otag <= 5'(r_tag); r_sect <= '0; r_tot <= '0; r_bi <= '0;
                    r_ls <= '0; r_stat <= r_cmd.done_status; r_sd <= r_nsec;
                    r_last <= 1'b1;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
